FILE: hw/rtl/hipt_pkg.sv
// Shared constants for the hashed inverted page table.
package hipt_pkg;

    localparam int BUCKETS_DEF = 16;
    localparam int FRAMES_DEF  = 32;

    localparam int PID_W      = 16;
    localparam int VA_W       = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = VA_W - PAGE_SHIFT;
    localparam int PA_W       = 17;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

endpackage

FILE: hw/rtl/hipt_hash.sv
// Bucket hash unit: key mod BUCKETS by reciprocal multiplication.
module hipt_hash #(
    parameter int BUCKETS = hipt_pkg::BUCKETS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [hipt_pkg::PAGE_W-1:0]          key,
    output logic                                 done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);
    import hipt_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KW = PAGE_W;
    localparam int MW = KW + 1;
    localparam int SH = KW + $clog2(BUCKETS);
    // ceil(2^SH / BUCKETS) gives the exact quotient for every KW-bit key
    localparam longint RECIP = ((longint'(1) << SH) + longint'(BUCKETS) - 1)
                               / longint'(BUCKETS);
    localparam logic [MW-1:0] MUL_K = MW'(RECIP);
    localparam logic [KW-1:0] DIV_K = KW'(BUCKETS);

    typedef enum logic [1:0] {
        H_IDLE, H_MUL, H_RED
    } hstate_t;

    hstate_t          hstate_reg;
    logic [KW-1:0]    key_reg;
    logic [KW+MW-1:0] prod_reg;
    logic [BW-1:0]    bucket_reg;
    logic             done_reg;
    logic [KW-1:0]    quot;
    logic [KW-1:0]    diff;

    // quotient times BUCKETS never exceeds the key, so KW bits hold it
    always_comb begin
        quot = KW'(prod_reg >> SH);
        diff = key_reg - KW'(quot * DIV_K);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hstate_reg <= H_IDLE;
            key_reg    <= '0;
            prod_reg   <= '0;
            bucket_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (hstate_reg)
                H_IDLE: begin
                    if (start) begin
                        key_reg    <= key;
                        hstate_reg <= H_MUL;
                    end
                end
                H_MUL: begin
                    // effectively a KW by MW product
                    prod_reg   <= {{MW{1'b0}}, key_reg} * {{KW{1'b0}}, MUL_K};
                    hstate_reg <= H_RED;
                end
                H_RED: begin
                    bucket_reg <= diff[BW-1:0];
                    done_reg   <= 1'b1;
                    hstate_reg <= H_IDLE;
                end
                default: begin
                    hstate_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

FILE: hw/rtl/hashed_inverted_page_table.sv
// Hashed inverted page table: translates (pid, virtual address), allocating on a miss.
//
//  channel | dir | tdata (low bit up)                          | tuser (low bit up)
//  s_      | in  | process_id[15:0], virtual_address[47:16]    | -
//  m_      | out | physical_address[16:0], zero pad to 24 bits | was_mapped, out_of_memory
//
// A miss passes the hash unit, the bucket read, the registered entry memory read and
// compare for each of L chain entries visited (at most FRAMES), the allocation, the
// load of the output register and the return to idle; a hit skips the allocation.
// After reset a clearing pass writes every entry of the bucket memory; s_tready
// stays low until it ends. One item is in work at a time; a finished result waits
// in the output register while m_tready is low, and the next item can be accepted
// meanwhile. A second result waits in S_DONE until the output register frees up.
module hashed_inverted_page_table #(
    parameter int BUCKETS = hipt_pkg::BUCKETS_DEF,
    parameter int FRAMES  = hipt_pkg::FRAMES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hipt_pkg::IN_DATA_W-1:0]    s_tdata,   // process_id, virtual_address
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hipt_pkg::OUT_DATA_W-1:0]   m_tdata,   // physical_address, pad
    output logic [hipt_pkg::OUT_USER_W-1:0]   m_tuser    // was_mapped, out_of_memory
);
    import hipt_pkg::*;

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FCW = $clog2(FRAMES + 1);
    localparam int PXW = FW + PAGE_SHIFT + PA_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_BREAD, S_BCHK, S_EREAD, S_ECMP, S_ALLOC, S_DONE
    } state_t;

    state_t state_reg;

    // memories
    logic [FW:0]       bucket_mem [BUCKETS];   // {valid, head}
    logic [PID_W-1:0]  owner_mem  [FRAMES];
    logic [PAGE_W-1:0] page_mem   [FRAMES];
    logic [FW:0]       next_mem   [FRAMES];    // {next_valid, next}

    logic [FW:0]       bkt_q;
    logic [PID_W-1:0]  owner_q;
    logic [PAGE_W-1:0] page_q;
    logic [FW:0]       next_q;

    logic [PID_W-1:0]      pid_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [PAGE_SHIFT-1:0] offset_reg;
    logic [FW-1:0]         cur_reg;
    logic [FCW-1:0]        steps_reg;
    logic [FCW-1:0]        free_reg;
    logic [BW-1:0]         clr_reg;

    logic [PA_W-1:0] res_pa_reg;
    logic            res_mapped_reg;
    logic            res_oom_reg;

    logic            m_tvalid_reg;
    logic [PA_W-1:0] m_pa_reg;
    logic            m_mapped_reg;
    logic            m_oom_reg;

    logic              hash_start;
    logic              hash_done;
    logic [BW-1:0]     hash_bucket;
    logic [PAGE_W-1:0] hash_key;

    logic              bkt_we;
    logic [BW-1:0]     bkt_waddr;
    logic [FW:0]       bkt_wdata;
    logic              ent_we;
    logic [FW-1:0]     alloc_frame;
    logic              in_accept;

    assign in_accept  = s_tvalid && s_tready;
    assign hash_start = in_accept;
    assign hash_key   = {{(PAGE_W-PID_W){1'b0}}, s_tdata[PID_W-1:0]}
                        ^ s_tdata[PID_W+VA_W-1:PID_W+PAGE_SHIFT];

    hipt_hash #(
        .BUCKETS(BUCKETS)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (hash_start),
        .key    (hash_key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign alloc_frame = FW'(free_reg - 1'b1);
    assign ent_we      = (state_reg == S_ALLOC) && (free_reg != '0);

    always_comb begin
        bkt_we    = 1'b0;
        bkt_waddr = hash_bucket;
        bkt_wdata = {1'b1, alloc_frame};
        if (state_reg == S_CLEAR) begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_reg;
            bkt_wdata = '0;
        end else if (ent_we) begin
            bkt_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_q <= bucket_mem[hash_bucket];
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            owner_mem[alloc_frame] <= pid_reg;
            page_mem[alloc_frame]  <= page_reg;
            next_mem[alloc_frame]  <= bkt_q[FW] ? bkt_q : '0;
        end
        owner_q <= owner_mem[cur_reg];
        page_q  <= page_mem[cur_reg];
        next_q  <= next_mem[cur_reg];
    end

    function automatic logic [PA_W-1:0] make_pa(input logic [FW-1:0] frame,
                                                input logic [PAGE_SHIFT-1:0] off);
        logic [PXW-1:0] full;
        full = PXW'({frame, off});
        return full[PA_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            free_reg     <= FCW'(FRAMES);
            m_tvalid_reg <= 1'b0;
            cur_reg      <= '0;
            steps_reg    <= '0;
        end else begin
            // S_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BW'(BUCKETS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        pid_reg    <= s_tdata[PID_W-1:0];
                        page_reg   <= s_tdata[PID_W+VA_W-1:PID_W+PAGE_SHIFT];
                        offset_reg <= s_tdata[PID_W+PAGE_SHIFT-1:PID_W];
                        state_reg  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        state_reg <= S_BREAD;
                    end
                end
                S_BREAD: begin
                    state_reg <= S_BCHK;
                end
                S_BCHK: begin
                    cur_reg   <= bkt_q[FW-1:0];
                    steps_reg <= '0;
                    state_reg <= bkt_q[FW] ? S_EREAD : S_ALLOC;
                end
                S_EREAD: begin
                    // walk ends on a runaway chain or a link beyond the table
                    if (steps_reg == FCW'(FRAMES) || FCW'(cur_reg) >= FCW'(FRAMES)) begin
                        state_reg <= S_ALLOC;
                    end else begin
                        state_reg <= S_ECMP;
                    end
                end
                S_ECMP: begin
                    if (owner_q == pid_reg && page_q == page_reg) begin
                        res_pa_reg     <= make_pa(cur_reg, offset_reg);
                        res_mapped_reg <= 1'b1;
                        res_oom_reg    <= 1'b0;
                        state_reg      <= S_DONE;
                    end else if (!next_q[FW]) begin
                        state_reg <= S_ALLOC;
                    end else begin
                        cur_reg   <= next_q[FW-1:0];
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_EREAD;
                    end
                end
                S_ALLOC: begin
                    res_mapped_reg <= 1'b0;
                    if (free_reg == '0) begin
                        res_pa_reg  <= '0;
                        res_oom_reg <= 1'b1;
                    end else begin
                        free_reg    <= free_reg - 1'b1;
                        res_pa_reg  <= make_pa(alloc_frame, offset_reg);
                        res_oom_reg <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_pa_reg     <= res_pa_reg;
                        m_mapped_reg <= res_mapped_reg;
                        m_oom_reg    <= res_oom_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-PA_W){1'b0}}, m_pa_reg};
    assign m_tuser  = {m_oom_reg, m_mapped_reg};

endmodule
